[rtl/core/csvp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field parser package
// Shared types, character codes and constants for the CSV field parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

	localparam logic [7:0] CHAR_QUOTE   = 8'h22;
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	localparam logic [2:0] COUNT_SAT  = 3'd5;
	localparam logic [2:0] NULL_LEN   = 3'd4;
	localparam int         QUEUE_DEPTH = 4;
	localparam int         MAX_RESULTS = 3;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_QUOTED = 2'd2,
		MODE_QSEEN  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic       is_field_end;
		logic [7:0] content_byte;
		logic       null_flag;
		logic       row_end;
		logic       last_of_run;
	} out_item_t;

	// All results caused by one input byte, in delivery order.
	typedef struct packed {
		logic [1:0]                    count;
		out_item_t [MAX_RESULTS-1:0]   res;
	} plan_t;

	// Letters of the null word, indexed by content position.
	function automatic logic [7:0] null_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = 8'h4E;
			2'd1:    c = 8'h55;
			default: c = 8'h4C;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/csvp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV parser front end
// Accepts text bytes, tracks the quoting mode and null-word match, and turns
// each byte into a plan of up to three results for the back end.
// ----------------------------------------------------------------------------
module csvp_front
	import csvp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     data_valid,
	output logic     data_stall,
	input  in_item_t data,
	input  logic     q_full,
	output logic     push,
	output plan_t    plan
);

	mode_t      mode_q, mode_nxt;
	logic [2:0] cnt_q, cnt_nxt;
	logic       match_q, match_nxt;

	logic       accept;
	logic       pre_end, pre_row, do_emit, post_end, row_closed;
	logic [2:0] c0, c1;
	logic       m0, m1;
	logic [7:0] b;

	assign data_stall = q_full;
	assign accept     = data_valid && !q_full;
	assign b          = data.data_byte;

	// Classification of the byte against the current mode.
	always_comb begin
		mode_nxt   = mode_q;
		pre_end    = 1'b0;
		pre_row    = 1'b0;
		do_emit    = 1'b0;
		row_closed = 1'b0;
		unique case (mode_q)
			MODE_START: begin
				if (b == CHAR_QUOTE) begin
					mode_nxt = MODE_QUOTED;
				end else if (b == CHAR_COMMA) begin
					pre_end = 1'b1;
				end else if (b == CHAR_NEWLINE) begin
					pre_end    = 1'b1;
					pre_row    = 1'b1;
					row_closed = 1'b1;
				end else begin
					mode_nxt = MODE_PLAIN;
					do_emit  = 1'b1;
				end
			end
			MODE_PLAIN: begin
				if (b == CHAR_COMMA) begin
					pre_end = 1'b1;
				end else if (b == CHAR_NEWLINE) begin
					pre_end    = 1'b1;
					pre_row    = 1'b1;
					row_closed = 1'b1;
				end else begin
					do_emit = 1'b1;
				end
			end
			MODE_QUOTED: begin
				if (b == CHAR_QUOTE) begin
					mode_nxt = MODE_QSEEN;
				end else begin
					do_emit = 1'b1;
				end
			end
			MODE_QSEEN: begin
				if (b == CHAR_QUOTE) begin
					mode_nxt = MODE_QUOTED;
					do_emit  = 1'b1;
				end else if (b == CHAR_COMMA) begin
					pre_end = 1'b1;
				end else if (b == CHAR_NEWLINE) begin
					pre_end    = 1'b1;
					pre_row    = 1'b1;
					row_closed = 1'b1;
				end else begin
					// The closing quote ends the field and this byte opens a plain one.
					pre_end  = 1'b1;
					mode_nxt = MODE_PLAIN;
					do_emit  = 1'b1;
				end
			end
			default: begin
				mode_nxt = MODE_START;
			end
		endcase
		if (pre_end && !do_emit) begin
			mode_nxt = MODE_START;
		end
		post_end = data.end_of_data && !row_closed;
	end

	// Field statistics before and after the content byte.
	always_comb begin
		c0 = pre_end ? 3'd0 : cnt_q;
		m0 = pre_end ? 1'b1 : match_q;
		if (c0 < NULL_LEN) begin
			m1 = m0 && (b == null_char(c0[1:0]));
		end else begin
			m1 = 1'b0;
		end
		c1        = (c0 < COUNT_SAT) ? c0 + 3'd1 : c0;
		cnt_nxt   = do_emit ? c1 : c0;
		match_nxt = do_emit ? m1 : m0;
	end

	// Pack the results in order: closing marker, content byte, end-of-data marker.
	always_comb begin
		out_item_t  r_pre, r_emit, r_post;
		logic [1:0] n;
		r_pre               = '0;
		r_pre.is_field_end  = 1'b1;
		r_pre.null_flag     = (cnt_q == 3'd0) || (cnt_q == NULL_LEN && match_q);
		r_pre.row_end       = pre_row;
		r_pre.last_of_run   = !do_emit && !post_end;
		r_emit              = '0;
		r_emit.content_byte = b;
		r_emit.last_of_run  = !post_end;
		r_post               = '0;
		r_post.is_field_end  = 1'b1;
		r_post.null_flag     = (cnt_nxt == 3'd0) || (cnt_nxt == NULL_LEN && match_nxt);
		r_post.row_end       = 1'b1;
		r_post.last_of_run   = 1'b1;
		plan = '0;
		n    = 2'd0;
		if (pre_end) begin
			plan.res[n] = r_pre;
			n           = n + 2'd1;
		end
		if (do_emit) begin
			plan.res[n] = r_emit;
			n           = n + 2'd1;
		end
		if (post_end) begin
			plan.res[n] = r_post;
			n           = n + 2'd1;
		end
		plan.count = n;
	end

	assign push = accept && (plan.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			cnt_q   <= 3'd0;
			match_q <= 1'b1;
		end else if (accept) begin
			if (data.end_of_data) begin
				mode_q  <= MODE_START;
				cnt_q   <= 3'd0;
				match_q <= 1'b1;
			end else begin
				mode_q  <= mode_nxt;
				cnt_q   <= cnt_nxt;
				match_q <= match_nxt;
			end
		end
	end

	a_eod_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && data.end_of_data |=> mode_q == MODE_START && cnt_q == 3'd0 && match_q)
		else $error("state not cleared after end of data");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_SAT)
		else $error("content count above saturation");

	a_qseen_split: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q == MODE_QSEEN && !data.end_of_data && b != CHAR_QUOTE
		&& b != CHAR_COMMA && b != CHAR_NEWLINE |-> plan.count == 2'd2)
		else $error("byte after closing quote must give marker and content");

endmodule

[rtl/core/csvp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV parser plan queue
// Short register FIFO of result plans between the front and back ends.
// ----------------------------------------------------------------------------
module csvp_queue
	import csvp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t push_data,
	input  logic  pop,
	output plan_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	plan_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> fill_q == $past(fill_q) + 1'b1)
		else $error("fill count did not follow push");

endmodule

[rtl/core/csvp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV parser back end
// Unrolls each queued plan into single results through an output register.
// ----------------------------------------------------------------------------
module csvp_back
	import csvp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  plan_t     head,
	input  logic      empty,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic       valid_q;
	out_item_t  data_q;
	logic [1:0] idx_q;
	logic       load, last_of_plan;

	assign load         = !empty && (!valid_q || !result_stall);
	assign last_of_plan = (idx_q == head.count - 2'd1);
	assign pop          = load && last_of_plan;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= head.res[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (!valid_q || !result_stall) begin
				valid_q <= !empty;
			end
			if (load) begin
				idx_q <= last_of_plan ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	a_idx_in_plan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> idx_q < head.count)
		else $error("result index beyond plan");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> $past(head.res[idx_q].last_of_run) && result.last_of_run)
		else $error("plan retired before its last result");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> idx_q == 2'd0)
		else $error("index left mid-plan with empty queue");

endmodule

[rtl/core/csv_field_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field parser unit
// Streaming CSV reader with quoted fields and null detection.
// ----------------------------------------------------------------------------
// Usage: bytes of text enter on the data channel (data_valid, data_stall,
// data), with end_of_data set on the final byte. Each byte gives zero to three
// results on the result channel: content bytes of the current field as they
// arrive, and a field-end marker carrying the null and row-end flags. The
// last result caused by a byte has last_of_run set; bytes that only change
// the quoting mode give no result.
// A byte's first result goes through the plan queue and the output register.
// The front end takes one byte per cycle unless data_stall is high; the back end
// delivers one result per cycle unless result_stall is high, so sustained input
// rate is one byte per cycle as long as bytes average at most one result, set by
// the single output register. A QUEUE_DEPTH-entry plan queue absorbs bursts;
// data_stall rises when it is full. Reset clears the parser state to field start
// and empties the queue and output register. While result_stall is high the
// output holds, the queue fills, and then data_stall holds off further bytes.
// ----------------------------------------------------------------------------
module csv_field_parser_unit
	import csvp_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      data_valid,
	output logic      data_stall,
	input  in_item_t  data,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic  push, pop, q_full, q_empty;
	plan_t plan, head;

	csvp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data       (data),
		.q_full     (q_full),
		.push       (push),
		.plan       (plan)
	);

	csvp_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (plan),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	csvp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
